FILE: hw/rtl/variance_weighted_stop_selector_unit_defines.svh
`ifndef VARIANCE_WEIGHTED_STOP_SELECTOR_UNIT_DEFINES_SVH
`define VARIANCE_WEIGHTED_STOP_SELECTOR_UNIT_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define VWSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define VWSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vwss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vwss_pkg;

  localparam int VWSS_MAX_SAMPLES = 4096;
  localparam int DIST_W  = 24;
  localparam int CFG_W   = 13;
  localparam int LAB_W   = 12;
  localparam int SCORE_W = 32;

  localparam int VWSS_L   = $clog2(VWSS_MAX_SAMPLES);
  localparam int VWSS_IW  = $clog2(VWSS_MAX_SAMPLES + 1);
  localparam int VWSS_DW  = 2 * DIST_W + VWSS_L + VWSS_IW + DIST_W;
  localparam int VWSS_ALU_W = VWSS_DW + (VWSS_DW % 2);

  typedef enum logic [1:0] {
    REG_MIN_POS,
    REG_MAX_POS,
    REG_TRAIN,
    REG_LABELED
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last;
  } in_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] predicted_count;
    logic             valid_res;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vwss_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module vwss_alu import vwss_pkg::*; #(
  parameter int W = VWSS_ALU_W
) (
  input  logic         clk,
  input  logic         rst,
  input  alu_cmd_t     cmd,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int CNT_W = $clog2(W + 1);
  localparam int HALF  = W / 2;

  logic             busy;
  alu_op_t          op_q;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       acc;
  logic [W-1:0]     x;
  logic [W-1:0]     y;
  logic [W-1:0]     q;

  logic [W:0]   add_a;
  logic [W:0]   add_b;
  logic         sub;
  logic [W+1:0] sum;
  logic         ok;

  always_comb begin
    unique case (op_q)
      ALU_DIV: begin
        add_a = {acc[W-1:0], x[W-1]};
        add_b = {1'b0, y};
        sub   = 1'b1;
      end
      ALU_SQRT: begin
        add_a = {acc[W-2:0], x[W-1:W-2]};
        add_b = {q[W-2:0], 2'b01};
        sub   = 1'b1;
      end
      default: begin
        add_a = acc;
        add_b = {1'b0, x};
        sub   = 1'b0;
      end
    endcase
    sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + (W+2)'(sub);
    ok  = sum[W+1];
  end

  assign res = (op_q == ALU_MUL) ? acc[W-1:0] : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (op_q == ALU_MUL) begin
          if (y == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q <= cmd.op;
      acc  <= '0;
      q    <= '0;
      x    <= a;
      y    <= b;
      cnt  <= (cmd.op == ALU_SQRT) ? CNT_W'(HALF) : CNT_W'(W);
    end else if (busy) begin
      unique case (op_q)
        ALU_DIV: begin
          acc <= ok ? sum[W:0] : add_a;
          q   <= {q[W-2:0], ok};
          x   <= x << 1;
          cnt <= cnt - CNT_W'(1);
        end
        ALU_SQRT: begin
          acc <= ok ? sum[W:0] : add_a;
          q   <= {q[W-2:0], ok};
          x   <= x << 2;
          cnt <= cnt - CNT_W'(1);
        end
        default: begin
          if (y != '0) begin
            if (y[0]) begin
              acc <= sum[W:0];
            end
            x <= x << 1;
            y <= y >> 1;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/variance_weighted_stop_selector_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                Payload
// in        in_valid / in_ready      in_data  (distance, last)
// out       out_valid / out_ready    out_data (predicted_count, valid_res)
// cfg       cfg_we                   cfg_addr, cfg_data
//
// A sample outside the scoring window skips the arithmetic; a beat marked last then emits.
// A scored sample's time is set by the shared shift-add unit: two W-step divisions,
// a W/2-step square root and five multiplications, one multiplier bit per cycle.
// Reset is synchronous; no beat is taken while a sample is in work, and a final
// result waits in the output register while the next sample is taken.

module variance_weighted_stop_selector_unit import vwss_pkg::*; #(
  parameter int MAX_SAMPLES = VWSS_MAX_SAMPLES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int L     = $clog2(MAX_SAMPLES);
  localparam int IW    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = DIST_W + L;
  localparam int SQ_W  = 2 * DIST_W + L;
  localparam int DW    = SQ_W + IW + DIST_W;
  localparam int W     = DW + (DW % 2);
  localparam int CW    = ((IW > 14) ? IW : 14) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQR, S_ACC, S_NQ, S_SS, S_NN, S_VAR, S_SQRT,
    S_NUM, S_DEN, S_DIVQ, S_FIN, S_EMIT
  } state_t;

  state_t state;

  logic [CFG_W-1:0] min_pos;
  logic [CFG_W-1:0] max_pos;
  logic [CFG_W-1:0] train;
  logic [LAB_W-1:0] labeled;

  logic [IW-1:0]      index;
  logic [SUM_W-1:0]   sum;
  logic [SQ_W-1:0]    sq;
  logic [DIST_W-1:0]  prev;
  logic [SCORE_W-1:0] best_score;
  logic [CFG_W-1:0]   best_count;
  logic               have_best;

  logic [DIST_W-1:0]   d_q;
  logic                last_q;
  logic [2*DIST_W-1:0] dsq;
  logic [W-1:0]        hold;
  logic [W-1:0]        std;

  alu_cmd_t     cmd;
  logic [W-1:0] alu_a;
  logic [W-1:0] alu_b;
  logic         alu_done;
  logic [W-1:0] alu_res;

  logic [IW-1:0]        n;
  logic [SUM_W-1:0]     sum_next;
  logic [SQ_W-1:0]      sq_next;
  logic signed [CW-1:0] i_s;
  logic signed [CW-1:0] lo;
  logic signed [CW-1:0] hi;
  logic signed [CW-1:0] cap;
  logic                 in_win;
  logic [CFG_W-1:0]     u;
  logic [CFG_W-1:0]     ui;
  logic [DIST_W-1:0]    diff;
  logic [SCORE_W-1:0]   score;
  logic                 in_range;

  always_comb begin
    n        = index + IW'(1);
    sum_next = sum + SUM_W'(d_q);
    sq_next  = sq + SQ_W'(dsq);
    i_s      = signed'(CW'(index));
    lo       = signed'(CW'(min_pos)) - signed'(CW'(labeled)) + signed'(CW'(1));
    cap      = signed'(CW'(max_pos)) + signed'(CW'(2));
    hi       = ((cap < signed'(CW'(train))) ? cap : signed'(CW'(train)))
               - signed'(CW'(labeled));
    in_win   = (i_s >= lo) && (i_s >= signed'(CW'(1))) && (i_s < hi);
    u        = train - CFG_W'(labeled);
    ui       = u - CFG_W'(index);
    diff     = (d_q > prev) ? (d_q - prev) : (prev - d_q);
    score    = (alu_res[W-1:SCORE_W] != '0) ? '1 : alu_res[SCORE_W-1:0];
    in_range = (index < IW'(MAX_SAMPLES));
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pos <= '0;
      max_pos <= CFG_W'(4096);
      train   <= CFG_W'(4096);
      labeled <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_POS: min_pos <= cfg_data;
        REG_MAX_POS: max_pos <= cfg_data;
        REG_TRAIN:   train   <= cfg_data;
        REG_LABELED: labeled <= cfg_data[LAB_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      index      <= '0;
      sum        <= '0;
      sq         <= '0;
      prev       <= '0;
      best_score <= '0;
      best_count <= '0;
      have_best  <= 1'b0;
      out_valid  <= 1'b0;
      out_data   <= '0;
      cmd        <= '{start: 1'b0, op: ALU_MUL};
      alu_a      <= '0;
      alu_b      <= '0;
      d_q        <= '0;
      last_q     <= 1'b0;
      dsq        <= '0;
      hold       <= '0;
      std        <= '0;
    end else begin
      if (cmd.start) begin
        cmd.start <= 1'b0;
      end
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            d_q    <= in_data.distance;
            last_q <= in_data.last;
            state  <= in_range ? S_SQR : S_FIN;
          end
        end
        S_SQR: begin
          dsq   <= d_q * d_q;
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum_next;
          sq  <= sq_next;
          if (in_win) begin
            cmd   <= '{start: 1'b1, op: ALU_MUL};
            alu_a <= W'(sq_next);
            alu_b <= W'(n);
            state <= S_NQ;
          end else begin
            state <= S_FIN;
          end
        end
        S_NQ: begin
          if (alu_done) begin
            hold  <= alu_res;
            cmd   <= '{start: 1'b1, op: ALU_MUL};
            alu_a <= W'(sum);
            alu_b <= W'(sum);
            state <= S_SS;
          end
        end
        S_SS: begin
          if (alu_done) begin
            hold  <= (hold >= alu_res) ? (hold - alu_res) : '0;
            cmd   <= '{start: 1'b1, op: ALU_MUL};
            alu_a <= W'(n);
            alu_b <= W'(n);
            state <= S_NN;
          end
        end
        S_NN: begin
          if (alu_done) begin
            cmd   <= '{start: 1'b1, op: ALU_DIV};
            alu_a <= hold << DIST_W;
            alu_b <= alu_res;
            state <= S_VAR;
          end
        end
        S_VAR: begin
          if (alu_done) begin
            cmd   <= '{start: 1'b1, op: ALU_SQRT};
            alu_a <= alu_res;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (alu_done) begin
            std   <= (alu_res == '0) ? (W'(1) << DIST_W) : alu_res;
            cmd   <= '{start: 1'b1, op: ALU_MUL};
            alu_a <= W'(diff) << 28;
            alu_b <= W'(ui);
            state <= S_NUM;
          end
        end
        S_NUM: begin
          if (alu_done) begin
            hold  <= alu_res;
            cmd   <= '{start: 1'b1, op: ALU_MUL};
            alu_a <= std;
            alu_b <= W'(u);
            state <= S_DEN;
          end
        end
        S_DEN: begin
          if (alu_done) begin
            cmd   <= '{start: 1'b1, op: ALU_DIV};
            alu_a <= hold;
            alu_b <= alu_res;
            state <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (alu_done) begin
            if (!have_best || (score > best_score)) begin
              best_score <= score;
              best_count <= CFG_W'(labeled) + CFG_W'(index) - CFG_W'(1);
              have_best  <= 1'b1;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (in_range) begin
            prev  <= d_q;
            index <= index + IW'(1);
          end
          state <= last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.predicted_count <= have_best ? best_count : '0;
            out_data.valid_res       <= have_best;
            index      <= '0;
            sum        <= '0;
            sq         <= '0;
            prev       <= '0;
            best_score <= '0;
            best_count <= '0;
            have_best  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vwss_alu #(
    .W(W)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (alu_res)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/vwss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "variance_weighted_stop_selector_unit_defines.svh"

module vwss_checker import vwss_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  `VWSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")

  `VWSS_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "input taken again while a sample is in work")

  `VWSS_ASSERT_SAME(a_empty_result, out_valid && !out_data.valid_res, out_data.predicted_count == '0, "result without a score carries a nonzero count")

  `VWSS_ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !in_data.last, !$rose(out_valid), "result raised right after a beat that was not last")

endmodule

bind variance_weighted_stop_selector_unit vwss_checker u_vwss_checker (.*);

`default_nettype wire
